@@ rtl/imuaqf_pkg.sv @@
// shared constants, types and helper functions of the imu attitude filter
package imuaqf_pkg;

   // fixed-point format of the quaternion and number of refinement passes
   localparam int QUAT_FRAC_BITS     = 30;
   localparam int RSQRT_NEWTON_STEPS = 2;

   // reciprocal square root seed and scale constants, Q2.30
   localparam logic [31:0] SEED_C0   = 32'd1053448104;
   localparam logic [31:0] SEED_C1   = 32'd314491700;
   localparam logic [31:0] INV_SQRT2 = 32'd759250125;
   localparam logic [33:0] THREE_Q30 = 34'd3 << 30;

   // derived shift amounts
   localparam int RSQRT_SH_BASE = 45 - QUAT_FRAC_BITS;
   localparam int HG_SHIFT      = 57 - QUAT_FRAC_BITS;
   localparam int NT_W          = (RSQRT_NEWTON_STEPS > 1) ? $clog2(RSQRT_NEWTON_STEPS) : 1;

   // digit-serial multiplier geometry
   localparam int OP_W       = 33;
   localparam int DIGIT_W    = 16;
   localparam int MUL_DIGITS = 3;
   localparam int BSH_W      = DIGIT_W * MUL_DIGITS;
   localparam int PP_W       = OP_W + DIGIT_W + 1;
   localparam int PROD_W     = 2 * OP_W;
   localparam int HI_KEEP    = PROD_W - BSH_W;

   // lane counts
   localparam int LANES    = 3;
   localparam int QCOMP    = 4;
   localparam int QM_TERMS = 3;

   // wide accumulator constants
   localparam logic signed [67:0] SAT_HI  = 68'sd2147483647;
   localparam logic signed [67:0] SAT_LO  = -68'sd2147483647;
   localparam logic signed [67:0] HV2_OFS = 68'sd1 <<< (2 * QUAT_FRAC_BITS - 1);

   // register reset values
   localparam logic [31:0] TWO_KP_RST        = 32'd16777216;
   localparam logic [31:0] TWO_KI_RST        = 32'd0;
   localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd42949673;
   localparam logic signed [31:0] QUAT_ONE   = 32'sd1 <<< QUAT_FRAC_BITS;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TWO_KP        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TWO_KI        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 2'd2;

   // control states
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_NORM  = 6'b000010,
      S_ISSUE = 6'b000100,
      S_MUL   = 6'b001000,
      S_WB    = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   // micro-program steps, one multiply each
   typedef enum logic [4:0] {
      ST_AX, ST_AY, ST_AZ,
      ST_RSEED, ST_RHI, ST_RY2, ST_RMY, ST_RNEW,
      ST_AN,
      ST_HV0A, ST_HV0B, ST_HV1A, ST_HV1B, ST_HV2A, ST_HV2B,
      ST_HE0A, ST_HE0B, ST_HE1A, ST_HE1B, ST_HE2A, ST_HE2B,
      ST_KE, ST_KI, ST_KP,
      ST_HG, ST_QM, ST_SQ, ST_NN
   } step_type;

   // one product term of the quaternion integration
   typedef struct packed {
      logic [1:0] qi;
      logic [1:0] hi;
      logic       neg;
   } qterm_type;

   function automatic qterm_type qm_term(input logic [1:0] comp, input logic [1:0] term);
      qterm_type r;
      r = '0;
      case ({comp, term})
         4'b00_00: r = '{qi: 2'd1, hi: 2'd0, neg: 1'b1};
         4'b00_01: r = '{qi: 2'd2, hi: 2'd1, neg: 1'b1};
         4'b00_10: r = '{qi: 2'd3, hi: 2'd2, neg: 1'b1};
         4'b01_00: r = '{qi: 2'd0, hi: 2'd0, neg: 1'b0};
         4'b01_01: r = '{qi: 2'd2, hi: 2'd2, neg: 1'b0};
         4'b01_10: r = '{qi: 2'd3, hi: 2'd1, neg: 1'b1};
         4'b10_00: r = '{qi: 2'd0, hi: 2'd1, neg: 1'b0};
         4'b10_01: r = '{qi: 2'd1, hi: 2'd2, neg: 1'b1};
         4'b10_10: r = '{qi: 2'd3, hi: 2'd0, neg: 1'b0};
         4'b11_00: r = '{qi: 2'd0, hi: 2'd2, neg: 1'b0};
         4'b11_01: r = '{qi: 2'd1, hi: 2'd1, neg: 1'b0};
         4'b11_10: r = '{qi: 2'd2, hi: 2'd0, neg: 1'b1};
         default:  r = '0;
      endcase
      return r;
   endfunction

   // symmetric clamp to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sd2147483647;
      end else if (v < SAT_LO) begin
         r = -32'sd2147483647;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [67:0] sx68(input logic signed [31:0] v);
      return $signed({{36{v[31]}}, v});
   endfunction

   function automatic logic signed [OP_W-1:0] s33(input logic signed [31:0] v);
      return $signed({v[31], v});
   endfunction

   function automatic logic signed [OP_W-1:0] u33(input logic [31:0] v);
      return $signed({1'b0, v});
   endfunction

endpackage

@@ rtl/imuaqf_if.sv @@
// channel interfaces of the imu attitude filter

interface imuaqf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] gyro_x;
   logic signed [31:0] gyro_y;
   logic signed [31:0] gyro_z;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;

   modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                   input ready);
   modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                 output ready);
endinterface

interface imuaqf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] quat_w;
   logic signed [31:0] quat_x;
   logic signed [31:0] quat_y;
   logic signed [31:0] quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface imuaqf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/imu_attitude_quaternion_filter.sv @@
// imu attitude filter top level: micro-sequenced datapath around one digit-serial multiplier
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   gyro_x/y/z (Q8.24), accel_x/y/z (raw counts)
//   rsp_chan  out  valid/ready   quat_w/x/y/z (Q2.30)
//   csr_chan  in   valid/ready   index, data (two_kp, two_ki, sample_period)
//
// Every product goes through one 33x33 multiplier that takes 16-bit digits of the
// second operand one per cycle: each product is a load, three digits and a write back.
// With feedback an item takes 58 to 66 products plus the two normalize loops; with the
// accelerometer all zero the feedback products and the first normalize loop are skipped.
// One item at a time; the result register lets the next item enter while it waits.
// Reset is synchronous: identity attitude, zero integral, gains and sample period to their defaults.
module imu_attitude_quaternion_filter
   import imuaqf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   imuaqf_req_if.sink   req_chan,
   imuaqf_rsp_if.source rsp_chan,
   imuaqf_csr_if.sink   csr_chan
);

   // control and architectural state
   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] term_ff, term_in;
   logic [NT_W-1:0] nt_ff, nt_in;
   logic [1:0] dig_ff, dig_in;
   logic rs_quat_ff, rs_quat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] two_kp_ff, two_ki_ff, sample_period_ff;
   logic signed [31:0] q_ff [QCOMP], q_in [QCOMP];
   logic signed [31:0] ig_ff [LANES], ig_in [LANES];

   // working registers
   logic signed [31:0] g_ff [LANES], g_in [LANES];
   logic signed [15:0] ax_ff [LANES], ax_in [LANES];
   logic signed [31:0] an_ff [LANES], an_in [LANES];
   logic signed [31:0] hv_ff [LANES], hv_in [LANES];
   logic signed [31:0] he_ff [LANES], he_in [LANES];
   logic signed [31:0] hg_ff [LANES], hg_in [LANES];
   logic signed [31:0] nq_ff [QCOMP], nq_in [QCOMP];
   logic signed [31:0] rq_ff [QCOMP], rq_in [QCOMP];
   logic signed [67:0] acc_ff, acc_in;
   logic [63:0] x_ff, x_in;
   logic signed [5:0] k_ff, k_in;
   logic [31:0] y_ff, y_in;
   logic [31:0] c_ff, c_in;
   logic signed [31:0] edt_ff, edt_in;

   // multiplier registers
   logic signed [OP_W-1:0] a_op_ff, a_op_in;
   logic [BSH_W-1:0] b_sh_ff, b_sh_in;
   logic signed [PP_W-1:0] hi_ff, hi_in;
   logic [BSH_W-1:0] lo_ff, lo_in;

   // combinational helpers
   logic signed [OP_W-1:0] op_a, op_b;
   logic signed [DIGIT_W:0] dig_val;
   logic signed [PP_W-1:0] pp;
   logic signed [PP_W:0] msum;
   logic signed [67:0] prod68, p_qf, p_sh, p_hg, p_edt;
   logic signed [5:0] sh_sum;
   logic [4:0] sh;
   logic ki_on, accel_nz;
   qterm_type qt;
   logic [33:0] my;
   logic signed [31:0] qm_m;
   logic signed [67:0] qm_base, qm_val, sum_v;

   assign ki_on    = |two_ki_ff;
   assign accel_nz = (|req_chan.accel_x) | (|req_chan.accel_y) | (|req_chan.accel_z);
   assign sh_sum   = k_ff + 6'(RSQRT_SH_BASE);
   assign sh       = sh_sum[4:0];
   assign qt       = qm_term(idx_ff, term_ff);

   // product views
   assign prod68 = $signed({{(68 - PROD_W){hi_ff[HI_KEEP-1]}}, hi_ff[HI_KEEP-1:0], lo_ff});
   assign p_qf   = prod68 >>> QUAT_FRAC_BITS;
   assign p_sh   = prod68 >>> sh;
   assign p_hg   = prod68 >>> HG_SHIFT;
   assign p_edt  = prod68 >>> 32;
   assign my     = prod68[63:30];

   // digit-serial multiply: one 16-bit digit of b per cycle, top digit signed
   assign dig_val = (dig_ff == 2'(MUL_DIGITS - 1))
                    ? $signed({b_sh_ff[DIGIT_W-1], b_sh_ff[DIGIT_W-1:0]})
                    : $signed({1'b0, b_sh_ff[DIGIT_W-1:0]});
   assign pp   = a_op_ff * dig_val;
   assign msum = $signed({hi_ff[PP_W-1], hi_ff}) + $signed({pp[PP_W-1], pp});

   // operand selection per step
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         ST_AX:    begin op_a = $signed(33'(ax_ff[0])); op_b = $signed(33'(ax_ff[0])); end
         ST_AY:    begin op_a = $signed(33'(ax_ff[1])); op_b = $signed(33'(ax_ff[1])); end
         ST_AZ:    begin op_a = $signed(33'(ax_ff[2])); op_b = $signed(33'(ax_ff[2])); end
         ST_RSEED: begin
            op_a = u33(SEED_C1);
            op_b = x_ff[31] ? u33({2'b00, x_ff[30:1]}) : u33({2'b00, x_ff[29:0]});
         end
         ST_RHI:   begin op_a = u33(y_ff); op_b = u33(INV_SQRT2); end
         ST_RY2:   begin op_a = u33(y_ff); op_b = u33(y_ff); end
         ST_RMY:   begin op_a = u33(x_ff[31:0]); op_b = u33(c_ff); end
         ST_RNEW:  begin op_a = u33(y_ff); op_b = u33(c_ff); end
         ST_AN:    begin op_a = $signed(33'(ax_ff[idx_ff])); op_b = u33(y_ff); end
         ST_HV0A:  begin op_a = s33(q_ff[1]); op_b = s33(q_ff[3]); end
         ST_HV0B:  begin op_a = s33(q_ff[0]); op_b = s33(q_ff[2]); end
         ST_HV1A:  begin op_a = s33(q_ff[0]); op_b = s33(q_ff[1]); end
         ST_HV1B:  begin op_a = s33(q_ff[2]); op_b = s33(q_ff[3]); end
         ST_HV2A:  begin op_a = s33(q_ff[0]); op_b = s33(q_ff[0]); end
         ST_HV2B:  begin op_a = s33(q_ff[3]); op_b = s33(q_ff[3]); end
         ST_HE0A:  begin op_a = s33(an_ff[1]); op_b = s33(hv_ff[2]); end
         ST_HE0B:  begin op_a = s33(an_ff[2]); op_b = s33(hv_ff[1]); end
         ST_HE1A:  begin op_a = s33(an_ff[2]); op_b = s33(hv_ff[0]); end
         ST_HE1B:  begin op_a = s33(an_ff[0]); op_b = s33(hv_ff[2]); end
         ST_HE2A:  begin op_a = s33(an_ff[0]); op_b = s33(hv_ff[1]); end
         ST_HE2B:  begin op_a = s33(an_ff[1]); op_b = s33(hv_ff[0]); end
         ST_KE:    begin op_a = s33(he_ff[idx_ff]); op_b = u33(sample_period_ff); end
         ST_KI:    begin op_a = s33(edt_ff); op_b = u33(two_ki_ff); end
         ST_KP:    begin op_a = s33(he_ff[idx_ff]); op_b = u33(two_kp_ff); end
         ST_HG:    begin op_a = s33(g_ff[idx_ff]); op_b = u33(sample_period_ff); end
         ST_QM:    begin op_a = s33(q_ff[qt.qi]); op_b = s33(hg_ff[qt.hi]); end
         ST_SQ:    begin op_a = s33(nq_ff[idx_ff]); op_b = s33(nq_ff[idx_ff]); end
         ST_NN:    begin op_a = s33(nq_ff[idx_ff]); op_b = u33(y_ff); end
         default:  begin op_a = '0; op_b = '0; end
      endcase
   end

   // sequencer and write back
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      nt_in        = nt_ff;
      dig_in       = dig_ff;
      rs_quat_in   = rs_quat_ff;
      rsp_valid_in = rsp_valid_ff;
      q_in         = q_ff;
      ig_in        = ig_ff;
      g_in         = g_ff;
      ax_in        = ax_ff;
      an_in        = an_ff;
      hv_in        = hv_ff;
      he_in        = he_ff;
      hg_in        = hg_ff;
      nq_in        = nq_ff;
      rq_in        = rq_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      y_in         = y_ff;
      c_in         = c_ff;
      edt_in       = edt_ff;
      a_op_in      = a_op_ff;
      b_sh_in      = b_sh_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      qm_m         = sat32(p_qf);
      qm_base      = (term_ff == 2'd0) ? sx68(q_ff[idx_ff]) : acc_ff;
      qm_val       = qt.neg ? (qm_base - sx68(qm_m)) : (qm_base + sx68(qm_m));
      sum_v        = '0;

      // result register drains independently
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               g_in[0]  = req_chan.gyro_x;
               g_in[1]  = req_chan.gyro_y;
               g_in[2]  = req_chan.gyro_z;
               ax_in[0] = req_chan.accel_x;
               ax_in[1] = req_chan.accel_y;
               ax_in[2] = req_chan.accel_z;
               idx_in   = '0;
               step_in  = accel_nz ? ST_AX : ST_HG;
               state_in = S_ISSUE;
            end
         end
         S_NORM: begin
            // scale by powers of four into [1,4)
            if (|x_ff[63:32]) begin
               x_in = {2'b00, x_ff[63:2]};
               k_in = k_ff + 6'sd1;
            end else if (~|x_ff[31:30]) begin
               x_in = {x_ff[61:0], 2'b00};
               k_in = k_ff - 6'sd1;
            end else begin
               nt_in    = '0;
               step_in  = ST_RSEED;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            a_op_in  = op_a;
            b_sh_in  = {{(BSH_W - OP_W){op_b[OP_W-1]}}, op_b};
            hi_in    = '0;
            dig_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            hi_in   = $signed({{(DIGIT_W - 1){msum[PP_W]}}, msum[PP_W:DIGIT_W]});
            lo_in   = {msum[DIGIT_W-1:0], lo_ff[BSH_W-1:DIGIT_W]};
            b_sh_in = b_sh_ff >> DIGIT_W;
            dig_in  = dig_ff + 2'd1;
            if (dig_ff == 2'(MUL_DIGITS - 1)) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            state_in = S_ISSUE;
            unique case (step_ff) inside
               ST_AX: begin
                  acc_in  = prod68;
                  step_in = ST_AY;
               end
               ST_AY: begin
                  acc_in  = acc_ff + prod68;
                  step_in = ST_AZ;
               end
               ST_AZ: begin
                  sum_v      = acc_ff + prod68;
                  x_in       = sum_v[63:0];
                  k_in       = '0;
                  rs_quat_in = 1'b0;
                  state_in   = S_NORM;
               end
               ST_RSEED: begin
                  y_in    = SEED_C0 - prod68[61:30];
                  step_in = x_ff[31] ? ST_RHI : ST_RY2;
               end
               ST_RHI: begin
                  y_in    = prod68[61:30];
                  step_in = ST_RY2;
               end
               ST_RY2: begin
                  c_in    = prod68[61:30];
                  step_in = ST_RMY;
               end
               ST_RMY: begin
                  c_in    = (my >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - my);
                  step_in = ST_RNEW;
               end
               ST_RNEW: begin
                  y_in = prod68[62:31];
                  if (nt_ff == NT_W'(RSQRT_NEWTON_STEPS - 1)) begin
                     idx_in  = '0;
                     step_in = rs_quat_ff ? ST_NN : ST_AN;
                  end else begin
                     nt_in   = nt_ff + 1'b1;
                     step_in = ST_RY2;
                  end
               end
               ST_AN: begin
                  an_in[idx_ff] = sat32(p_sh);
                  if (idx_ff == 2'(LANES - 1)) begin
                     step_in = ST_HV0A;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
               ST_HV0A, ST_HV1A, ST_HV2A, ST_HE0A, ST_HE1A, ST_HE2A: begin
                  acc_in  = prod68;
                  step_in = step_type'(step_ff + 5'd1);
               end
               ST_HV0B: begin
                  hv_in[0] = sat32((acc_ff - prod68) >>> QUAT_FRAC_BITS);
                  step_in  = ST_HV1A;
               end
               ST_HV1B: begin
                  hv_in[1] = sat32((acc_ff + prod68) >>> QUAT_FRAC_BITS);
                  step_in  = ST_HV2A;
               end
               ST_HV2B: begin
                  hv_in[2] = sat32((acc_ff + prod68 - HV2_OFS) >>> QUAT_FRAC_BITS);
                  step_in  = ST_HE0A;
               end
               ST_HE0B: begin
                  he_in[0] = sat32((acc_ff - prod68) >>> QUAT_FRAC_BITS);
                  step_in  = ST_HE1A;
               end
               ST_HE1B: begin
                  he_in[1] = sat32((acc_ff - prod68) >>> QUAT_FRAC_BITS);
                  step_in  = ST_HE2A;
               end
               ST_HE2B: begin
                  he_in[2] = sat32((acc_ff - prod68) >>> QUAT_FRAC_BITS);
                  idx_in   = '0;
                  step_in  = ki_on ? ST_KE : ST_KP;
               end
               ST_KE: begin
                  edt_in  = p_edt[31:0];
                  step_in = ST_KI;
               end
               ST_KI: begin
                  ig_in[idx_ff] = sat32(sx68(ig_ff[idx_ff]) + p_qf);
                  step_in       = ST_KP;
               end
               ST_KP: begin
                  // proportional term plus the integral that was just updated
                  sum_v = sx68(g_ff[idx_ff]) + p_qf;
                  if (ki_on) begin
                     sum_v = sum_v + sx68(ig_ff[idx_ff]);
                  end else begin
                     ig_in[idx_ff] = '0;
                  end
                  g_in[idx_ff] = sat32(sum_v);
                  if (idx_ff == 2'(LANES - 1)) begin
                     idx_in  = '0;
                     step_in = ST_HG;
                  end else begin
                     idx_in  = idx_ff + 2'd1;
                     step_in = ki_on ? ST_KE : ST_KP;
                  end
               end
               ST_HG: begin
                  hg_in[idx_ff] = sat32(p_hg);
                  if (idx_ff == 2'(LANES - 1)) begin
                     idx_in  = '0;
                     term_in = '0;
                     step_in = ST_QM;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
               ST_QM: begin
                  // idx is the component, term walks its three products
                  if (term_ff == 2'(QM_TERMS - 1)) begin
                     nq_in[idx_ff] = sat32(qm_val);
                     term_in       = '0;
                     if (idx_ff == 2'(QCOMP - 1)) begin
                        idx_in  = '0;
                        step_in = ST_SQ;
                     end else begin
                        idx_in = idx_ff + 2'd1;
                     end
                  end else begin
                     acc_in  = qm_val;
                     term_in = term_ff + 2'd1;
                  end
               end
               ST_SQ: begin
                  sum_v  = ((idx_ff == 2'd0) ? 68'sd0 : acc_ff) + prod68;
                  acc_in = sum_v;
                  if (idx_ff == 2'(QCOMP - 1)) begin
                     if (sum_v == 68'sd0) begin
                        state_in = S_FIN;
                     end else begin
                        x_in       = sum_v[63:0];
                        k_in       = '0;
                        rs_quat_in = 1'b1;
                        state_in   = S_NORM;
                     end
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
               ST_NN: begin
                  nq_in[idx_ff] = sat32(p_sh);
                  if (idx_ff == 2'(QCOMP - 1)) begin
                     state_in = S_FIN;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rq_in        = nq_ff;
               q_in         = nq_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_AX;
         idx_ff       <= '0;
         term_ff      <= '0;
         nt_ff        <= '0;
         dig_ff       <= '0;
         rs_quat_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         q_ff[0]      <= QUAT_ONE;
         q_ff[1]      <= '0;
         q_ff[2]      <= '0;
         q_ff[3]      <= '0;
         for (int i = 0; i < LANES; i++) begin
            ig_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         term_ff      <= term_in;
         nt_ff        <= nt_in;
         dig_ff       <= dig_in;
         rs_quat_ff   <= rs_quat_in;
         rsp_valid_ff <= rsp_valid_in;
         q_ff         <= q_in;
         ig_ff        <= ig_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         two_kp_ff        <= TWO_KP_RST;
         two_ki_ff        <= TWO_KI_RST;
         sample_period_ff <= SAMPLE_PERIOD_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_TWO_KP:        two_kp_ff        <= csr_chan.data;
            CSR_TWO_KI:        two_ki_ff        <= csr_chan.data;
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      g_ff    <= g_in;
      ax_ff   <= ax_in;
      an_ff   <= an_in;
      hv_ff   <= hv_in;
      he_ff   <= he_in;
      hg_ff   <= hg_in;
      nq_ff   <= nq_in;
      rq_ff   <= rq_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      k_ff    <= k_in;
      y_ff    <= y_in;
      c_ff    <= c_in;
      edt_ff  <= edt_in;
      a_op_ff <= a_op_in;
      b_sh_ff <= b_sh_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
   end

   // ports
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.quat_w = rq_ff[0];
   assign rsp_chan.quat_x = rq_ff[1];
   assign rsp_chan.quat_y = rq_ff[2];
   assign rsp_chan.quat_z = rq_ff[3];

endmodule

@@ rtl/imuaqf_checker.sv @@
// port-level assertions of the imu attitude filter, bound to the top level
module imuaqf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] quat_w,
   input logic [31:0] quat_x,
   input logic [31:0] quat_y,
   input logic [31:0] quat_z
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one item at a time: input closes right after an item is taken
   a_req_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still open after item taken");

   // a fresh result appears only as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while still busy");

   // saturation is symmetric, so the most negative code never shows
   a_sat_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (quat_w != 32'h8000_0000) && (quat_x != 32'h8000_0000) &&
                    (quat_y != 32'h8000_0000) && (quat_z != 32'h8000_0000))
      else $error("asymmetric saturation code on output");

endmodule

bind imu_attitude_quaternion_filter imuaqf_checker u_imuaqf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .quat_w    (rsp_chan.quat_w),
   .quat_x    (rsp_chan.quat_x),
   .quat_y    (rsp_chan.quat_y),
   .quat_z    (rsp_chan.quat_z)
);
